FILE: rtl/prime_power_factorization_top_macros.svh
// Assertion macros shared by the checker files.
`ifndef PRIME_POWER_FACTORIZATION_TOP_MACROS_SVH
`define PRIME_POWER_FACTORIZATION_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PPF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PPF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ppf_pkg.sv
package ppf_pkg;

  // Exponent field width and its saturation value
  localparam int unsigned EXP_W = 5;
  localparam logic [EXP_W-1:0] EXP_MAX = 5'd31;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_START,
    ST_WAIT,
    ST_FETCH,
    ST_EMIT
  } ppf_state_t;

  // Divider status back to the sequencer
  typedef struct packed {
    logic done;      // one-cycle pulse, quotient and remainder valid
    logic rem_zero;  // remainder of the last division is zero
  } div_stat_t;

endpackage

FILE: rtl/ppf_in_if.sv
interface ppf_in_if #(
  parameter int VALUE_BITS = 31
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

FILE: rtl/ppf_out_if.sv
interface ppf_out_if #(
  parameter int VALUE_BITS = 31
);
  logic                       valid;
  logic                       ready;
  logic [VALUE_BITS-1:0]      prime;
  logic [ppf_pkg::EXP_W-1:0]  exponent;
  logic                       no_factors;
  logic                       last;

  modport source (output valid, output prime, output exponent, output no_factors,
                  output last, input ready);
  modport sink   (input valid, input prime, input exponent, input no_factors,
                  input last, output ready);
endinterface

FILE: rtl/ppf_div.sv
// Restoring divider, one quotient bit per cycle.
module ppf_div #(
  parameter int VALUE_BITS = 31,
  parameter int DIV_BITS   = 17
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [DIV_BITS-1:0]   divisor,
  output logic [VALUE_BITS-1:0] quotient,
  output ppf_pkg::div_stat_t    stat
);

  localparam int CNT_W = $clog2(VALUE_BITS + 1);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [VALUE_BITS-1:0] q_r, q_nxt;
  logic [DIV_BITS-1:0]   part_r, part_nxt;
  logic [DIV_BITS-1:0]   dvs_r, dvs_nxt;

  logic [DIV_BITS:0]     trial;
  logic [DIV_BITS:0]     diff;
  logic                  fits;

  // one shift-subtract step
  assign trial = {part_r, q_r[VALUE_BITS-1]};
  assign fits  = (trial >= {1'b0, dvs_r});
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    part_nxt = part_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(VALUE_BITS);
      q_nxt    = dividend;
      part_nxt = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      q_nxt    = {q_r[VALUE_BITS-2:0], fits};
      part_nxt = fits ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
      cnt_nxt  = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    q_r    <= q_nxt;
    part_r <= part_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign quotient      = q_r;
  assign stat.done     = done_r;
  assign stat.rem_zero = (part_r == '0);

endmodule

FILE: rtl/ppf_stack.sv
// Generic RAM: one write port, one registered read port, no reset on the entries.
module ppf_stack #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 9
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/prime_power_factorization_top.sv
// Channel   Dir  Payload                              Handshake
// in_ch     in   value                                valid / ready
// out_ch    out  prime, exponent, no_factors, last    valid / ready
//
// Each trial divisor goes through a compare, a launch and a bit-serial
// divide, and each successful division relaunches the divider; the serial
// divider sets the rate. Worst case at 31 bits (a large prime) is about
// 46341 trials. Inputs below two go from idle straight to emit.
// Synchronous active-low reset; in_ch.ready is high only while idle.
// Each factor result waits for a stack read, so results never come back to
// back; a stalled out_ch holds the current result and delays the rest.
module prime_power_factorization_top #(
  parameter int VALUE_BITS  = 31,
  parameter int MAX_FACTORS = 9
) (
  input logic       clk,
  input logic       rst_n,
  ppf_in_if.sink    in_ch,
  ppf_out_if.source out_ch
);

  localparam int DIV_BITS = (VALUE_BITS + 1) / 2 + 1;
  localparam int SQ_W     = VALUE_BITS + 1;
  localparam int CNT_W    = $clog2(MAX_FACTORS + 1);
  localparam int IDX_W    = $clog2(MAX_FACTORS);
  localparam int EW       = ppf_pkg::EXP_W;
  localparam int SW       = VALUE_BITS + EW;

  ppf_pkg::ppf_state_t   state_r, state_nxt;
  logic [VALUE_BITS-1:0] rem_r, rem_nxt;
  logic [DIV_BITS-1:0]   d_r, d_nxt;
  logic [SQ_W-1:0]       sq_r, sq_nxt;
  logic [EW-1:0]         e_r, e_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  none_r, none_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [VALUE_BITS-1:0] out_prime_r, out_prime_nxt;
  logic [EW-1:0]         out_exp_r, out_exp_nxt;
  logic                  out_none_r, out_none_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  push_req;
  logic [VALUE_BITS-1:0] push_prime;
  logic [EW-1:0]         push_exp;
  logic                  stack_we;
  logic [CNT_W-1:0]      cnt_m1;
  logic [SW-1:0]         rd_word;
  logic [VALUE_BITS-1:0] rd_prime;
  logic [EW-1:0]         rd_exp;

  logic                  div_start;
  logic [VALUE_BITS-1:0] div_quot;
  ppf_pkg::div_stat_t    div_stat;

  assign cnt_m1   = cnt_r - CNT_W'(1);
  assign stack_we = push_req && (cnt_r < CNT_W'(MAX_FACTORS));
  assign rd_prime = rd_word[SW-1:EW];
  assign rd_exp   = rd_word[EW-1:0];

  ppf_div #(
    .VALUE_BITS (VALUE_BITS),
    .DIV_BITS   (DIV_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rem_r),
    .divisor  (d_r),
    .quotient (div_quot),
    .stat     (div_stat)
  );

  ppf_stack #(
    .WIDTH (SW),
    .DEPTH (MAX_FACTORS)
  ) u_stack (
    .clk   (clk),
    .we    (stack_we),
    .waddr (cnt_r[IDX_W-1:0]),
    .wdata ({push_prime, push_exp}),
    .raddr (cnt_m1[IDX_W-1:0]),
    .rdata (rd_word)
  );

  // sequencer: next state, datapath updates and output loading
  always_comb begin
    state_nxt     = state_r;
    rem_nxt       = rem_r;
    d_nxt         = d_r;
    sq_nxt        = sq_r;
    e_nxt         = e_r;
    cnt_nxt       = cnt_r;
    none_nxt      = none_r;
    out_prime_nxt = out_prime_r;
    out_exp_nxt   = out_exp_r;
    out_none_nxt  = out_none_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    push_req      = 1'b0;
    push_prime    = rem_r;
    push_exp      = EW'(1);
    div_start     = 1'b0;

    unique case (state_r)
      ppf_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          rem_nxt = in_ch.value;
          cnt_nxt = '0;
          d_nxt   = DIV_BITS'(2);
          sq_nxt  = SQ_W'(4);
          e_nxt   = '0;
          if (in_ch.value < VALUE_BITS'(2)) begin
            none_nxt  = 1'b1;
            state_nxt = ppf_pkg::ST_EMIT;
          end else begin
            state_nxt = ppf_pkg::ST_CHECK;
          end
        end
      end

      // keep trying while d*d <= remainder, else a remainder above one is prime
      ppf_pkg::ST_CHECK: begin
        if (sq_r <= {1'b0, rem_r}) begin
          state_nxt = ppf_pkg::ST_START;
        end else begin
          if (rem_r > VALUE_BITS'(1)) begin
            push_req = 1'b1;
          end
          state_nxt = ppf_pkg::ST_FETCH;
        end
      end

      ppf_pkg::ST_START: begin
        div_start = 1'b1;
        state_nxt = ppf_pkg::ST_WAIT;
      end

      // divides: take quotient, retry; else push any factor, next divisor
      ppf_pkg::ST_WAIT: begin
        if (div_stat.done) begin
          if (div_stat.rem_zero) begin
            rem_nxt   = div_quot;
            e_nxt     = (e_r == ppf_pkg::EXP_MAX) ? e_r : e_r + EW'(1);
            state_nxt = ppf_pkg::ST_START;
          end else begin
            if (e_r != '0) begin
              push_req   = 1'b1;
              push_prime = {{(VALUE_BITS-DIV_BITS){1'b0}}, d_r};
              push_exp   = e_r;
            end
            d_nxt     = d_r + DIV_BITS'(1);
            sq_nxt    = sq_r + SQ_W'({d_r, 1'b1});
            e_nxt     = '0;
            state_nxt = ppf_pkg::ST_CHECK;
          end
        end
      end

      // top of stack is read into the RAM output register
      ppf_pkg::ST_FETCH: begin
        state_nxt = ppf_pkg::ST_EMIT;
      end

      // pop stack to output reg, largest prime first; or no-factor result
      ppf_pkg::ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          if (none_r) begin
            out_prime_nxt = '0;
            out_exp_nxt   = '0;
            out_none_nxt  = 1'b1;
            out_last_nxt  = 1'b1;
            none_nxt      = 1'b0;
            state_nxt     = ppf_pkg::ST_IDLE;
          end else begin
            out_prime_nxt = rd_prime;
            out_exp_nxt   = rd_exp;
            out_none_nxt  = 1'b0;
            out_last_nxt  = (cnt_r == CNT_W'(1));
            cnt_nxt       = cnt_m1;
            if (cnt_r == CNT_W'(1)) begin
              state_nxt = ppf_pkg::ST_IDLE;
            end else begin
              state_nxt = ppf_pkg::ST_FETCH;
            end
          end
        end
      end

      default: state_nxt = ppf_pkg::ST_IDLE;
    endcase

    if (stack_we) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ppf_pkg::ST_IDLE;
      cnt_r       <= '0;
      none_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      none_r      <= none_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath and result payload
  always_ff @(posedge clk) begin
    rem_r       <= rem_nxt;
    d_r         <= d_nxt;
    sq_r        <= sq_nxt;
    e_r         <= e_nxt;
    out_prime_r <= out_prime_nxt;
    out_exp_r   <= out_exp_nxt;
    out_none_r  <= out_none_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign in_ch.ready       = (state_r == ppf_pkg::ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.prime      = out_prime_r;
  assign out_ch.exponent   = out_exp_r;
  assign out_ch.no_factors = out_none_r;
  assign out_ch.last       = out_last_r;

endmodule

FILE: rtl/ppf_checker.sv
`include "prime_power_factorization_top_macros.svh"

// Port-level checks on the factorizer.
module ppf_checker (
  input logic       clk,
  input logic       rst_n,
  ppf_in_if.sink    in_ch,
  ppf_out_if.source out_ch
);

  // a pending result stays offered until taken
  `PPF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid, "result dropped before it was taken")

  // one request at a time: busy right after an accept
  `PPF_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready, "ready right after accepting a request")

  // a no-factor result is alone and empty
  `PPF_ASSERT_NOW(a_none_shape, clk, rst_n, out_ch.valid && out_ch.no_factors, out_ch.last && out_ch.prime == '0 && out_ch.exponent == '0, "malformed no-factor result")

  // a real factor is at least two with a nonzero exponent
  `PPF_ASSERT_NOW(a_factor_shape, clk, rst_n, out_ch.valid && !out_ch.no_factors, out_ch.exponent != '0 && out_ch.prime > 1, "malformed factor result")

endmodule

bind prime_power_factorization_top ppf_checker u_ppf_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);
